>>> src/gosq_pkg.sv
package gosq_pkg;

    localparam int XW     = 16;
    localparam int YW     = 24;
    localparam int AW     = 24;
    localparam int SIGW   = 15;
    localparam int D2W    = 32;
    localparam int SUMW   = 63;
    localparam int EW     = 17;
    localparam int CFG_IW = 8;
    localparam int CFG_DW = 24;

    localparam logic [CFG_IW-1:0] REG_AMPLITUDE = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_CENTER    = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_WIDTH     = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] REG_OFFSET    = CFG_IW'(3);

    localparam logic [SUMW-1:0] SUM_MAX = {SUMW{1'b1}};

    // one classified sample between front and back
    typedef struct packed {
        logic [D2W-1:0] d2;
        logic           far;
        logic [YW-1:0]  y;
        logic           last;
    } t_item;

endpackage

>>> src/gosq_front.sv
module gosq_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [gosq_pkg::XW-1:0]      i_x,
    input  logic [gosq_pkg::YW-1:0]      i_y,
    input  logic                         i_last,
    input  logic [gosq_pkg::XW-1:0]      i_center,
    input  logic [gosq_pkg::SIGW-1:0]    i_width,
    input  logic                         i_full,
    output logic                         o_push,
    output gosq_pkg::t_item              o_item
);
    import gosq_pkg::*;

    logic               r_valid;
    logic [XW-1:0]      r_ad;
    logic [YW-1:0]      r_y;
    logic               r_last;
    logic [XW:0]        n_d;
    logic [XW-1:0]      n_ad;
    logic [D2W-1:0]     d2;
    logic [2*SIGW+4:0]  den;

    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;

    // distance from the peak, magnitude only
    always_comb begin
        n_d  = {i_x[XW-1], i_x} - {i_center[XW-1], i_center};
        n_ad = n_d[XW] ? XW'(-n_d) : n_d[XW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_ad   <= n_ad;
            r_y    <= i_y;
            r_last <= i_last;
        end
    end

    // classify: far when t >= 16 or sigma is zero
    always_comb begin
        d2          = D2W'(r_ad) * D2W'(r_ad);
        den         = {(2*SIGW)'(i_width) * (2*SIGW)'(i_width), 5'b0};
        o_item.d2   = d2;
        o_item.far  = (i_width == '0) || ((2*SIGW+5)'(d2) >= den);
        o_item.y    = r_y;
        o_item.last = r_last;
    end

endmodule

>>> src/gosq_fifo.sv
module gosq_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gosq_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output gosq_pkg::t_item  o_item
);
    import gosq_pkg::*;

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

>>> src/gosq_back.sv
module gosq_back #(
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  gosq_pkg::t_item               i_item,
    output logic                          o_pop,
    input  logic [gosq_pkg::AW-1:0]       i_amplitude,
    input  logic [gosq_pkg::SIGW-1:0]     i_width,
    input  logic [gosq_pkg::AW-1:0]       i_offset,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gosq_pkg::SUMW-1:0]     o_sum,
    output logic                          o_sat
);
    import gosq_pkg::*;

    localparam int KW  = $clog2(EXP_TABLE_DEPTH);
    localparam int CW  = 35 + KW;
    localparam int CNW = $clog2(KW);

    typedef logic [EW-1:0] t_rom [EXP_TABLE_DEPTH];

    function automatic logic [EW-1:0] exp_entry(input int k);
        logic [63:0] n;
        logic [63:0] rem;
        logic [63:0] r32;
        logic [63:0] term;
        logic [63:0] sum;
        n    = 64'((16 * k) / EXP_TABLE_DEPTH);
        rem  = 64'((16 * k) % EXP_TABLE_DEPTH);
        r32  = (rem << 32) / EXP_TABLE_DEPTH;
        term = 64'd1 << 32;
        sum  = term;
        for (int i = 1; i <= 20; i++) begin
            term = ((term * r32) >> 32) / 64'(i);
            if (i % 2 == 1) sum = sum - term;
            else            sum = sum + term;
        end
        for (int i = 0; i < 64'(n); i++) begin
            sum = (sum * 64'd1580030169 + (64'd1 << 31)) >> 32;
        end
        sum = (sum + (64'd1 << 15)) >> 16;
        return sum[EW-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom t;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) t[k] = exp_entry(k);
        return t;
    endfunction

    localparam t_rom EXP_ROM = build_rom();

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_ROM, ST_MUL, ST_RES, ST_SQ, ST_ACC
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_den;
    logic [CW-1:0]         r_rem;
    logic [KW-1:0]         r_k;
    logic [CNW-1:0]        r_cnt;
    logic [YW-1:0]         r_y;
    logic                  r_last;
    logic [EW-1:0]         r_e;
    logic signed [41:0]    r_prod;
    logic signed [26:0]    r_res;
    logic [53:0]           r_sq;
    logic [SUMW-1:0]       r_sum;
    logic                  r_clip;
    logic                  r_out_valid;
    logic [SUMW-1:0]       r_out_sum;
    logic                  r_out_sat;

    logic [CW-1:0]         trial;
    logic signed [41:0]    rnd;
    logic signed [25:0]    y0;
    logic [SUMW:0]         add;
    logic                  n_clip;
    logic [SUMW-1:0]       n_sum;
    logic                  acc_go;

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign o_valid = r_out_valid;
    assign o_sum   = r_out_sum;
    assign o_sat   = r_out_sat;

    always_comb begin
        trial  = r_den << r_cnt;
        rnd    = r_prod + 42'sd32768;
        y0     = 26'(signed'(rnd[40:16])) + 26'(signed'(i_offset));
        add    = {1'b0, r_sum} + 64'(r_sq);
        n_clip = r_clip || add[SUMW];
        n_sum  = add[SUMW] ? SUM_MAX : add[SUMW-1:0];
        acc_go = !(r_last && r_out_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        r_den <= CW'({(2*SIGW)'(i_width) * (2*SIGW)'(i_width), 5'b0});
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !(r_state == ST_ACC && r_last)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_rem  <= CW'(i_item.d2) * CW'(EXP_TABLE_DEPTH);
                        r_k    <= '0;
                        r_cnt  <= CNW'(KW - 1);
                        r_y    <= i_item.y;
                        r_last <= i_item.last;
                        r_e    <= '0;
                        r_state <= i_item.far ? ST_MUL : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_rem >= trial) begin
                        r_rem      <= r_rem - trial;
                        r_k[r_cnt] <= 1'b1;
                    end
                    if (r_cnt == '0) r_state <= ST_ROM;
                    else             r_cnt   <= r_cnt - CNW'(1);
                end
                ST_ROM: begin
                    r_e     <= EXP_ROM[r_k];
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= 42'(signed'(i_amplitude)) * 42'(signed'({1'b0, r_e}));
                    r_state <= ST_RES;
                end
                ST_RES: begin
                    r_res   <= 27'(y0) - 27'(signed'(r_y));
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_sq    <= 54'(r_res * r_res);
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (acc_go) begin
                        if (r_last) begin
                            r_out_valid <= 1'b1;
                            r_out_sum   <= n_sum;
                            r_out_sat   <= n_clip;
                            r_sum       <= '0;
                            r_clip      <= 1'b0;
                        end else begin
                            r_sum  <= n_sum;
                            r_clip <= n_clip;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> src/gaussian_offset_squared_error.sv
// channel | dir | handshake              | payload
// s_axis  | in  | s_axis_tvalid/tready   | tdata x_pos, y_value; tlast last_sample
// m_axis  | out | m_axis_tvalid/tready   | tdata error_sum; tuser saturated
// cfg     | in  | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// A sample in table range passes through the back's one-quotient-bit-per-cycle divider,
// which forms the table index, then the lookup, multiply, residual, square and accumulate;
// a far sample or a zero width skips the divider and the table.
// The front takes a new sample while the back works; a two-entry queue sits between.
// A waiting result stalls only the back, and only on a last sample.
// Reset is synchronous, active low; the configuration port never stalls.
module gaussian_offset_squared_error #(
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [15:0] x_pos, [39:16] y_value
    input  logic        s_axis_tlast,   // last_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [62:0] error_sum, [63] zero
    output logic        m_axis_tuser,   // [0] saturated
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [gosq_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [gosq_pkg::CFG_DW-1:0] i_cfg_data
);
    import gosq_pkg::*;

    logic [AW-1:0]   r_amplitude;
    logic [XW-1:0]   r_center;
    logic [SIGW-1:0] r_width;
    logic [AW-1:0]   r_offset;

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    t_item           front_item;
    t_item           queue_item;
    logic [SUMW-1:0] sum;

    assign o_cfg_ready = 1'b1;

    // configuration registers; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= AW'(256);
            r_center    <= '0;
            r_width     <= SIGW'(256);
            r_offset    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_AMPLITUDE: r_amplitude <= i_cfg_data;
                REG_CENTER:    r_center    <= i_cfg_data[XW-1:0];
                REG_WIDTH:     r_width     <= i_cfg_data[SIGW-1:0];
                REG_OFFSET:    r_offset    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: take the beat, form (x-x0)^2 and the far flag
    gosq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_x      (s_axis_tdata[15:0]),
        .i_y      (s_axis_tdata[39:16]),
        .i_last   (s_axis_tlast),
        .i_center (r_center),
        .i_width  (r_width),
        .i_full   (full),
        .o_push   (push),
        .o_item   (front_item)
    );

    gosq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    // back: index divide and table lookup (near samples only), scale, residual, square, accumulate
    gosq_back #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_item      (queue_item),
        .o_pop       (pop),
        .i_amplitude (r_amplitude),
        .i_width     (r_width),
        .i_offset    (r_offset),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_sum       (sum),
        .o_sat       (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, sum};

endmodule
